// File: sv/cft_pkg.sv
// Shared types and constants for the coarse/fine microsecond timestamp block.
// No dependencies; only the top level coarse_fine_microsecond_timestamp imports this package.
package cft_pkg;

  localparam int FINE_BITS_DEF = 32;
  localparam int HZ_W          = 30;
  localparam int UPT_W         = 20;
  localparam int COUNT_W       = 32;
  localparam int TICK_US_W     = COUNT_W + UPT_W;
  localparam int TIME_W        = 53;
  localparam int CFG_IDX_W     = 3;

  localparam logic [UPT_W-1:0] US_PER_SEC = 20'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_BUS_HZ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_HZ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUL_SEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_US_TICK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_EN  = 3'd4;

  localparam logic [HZ_W-1:0]  BUS_HZ_RST  = 30'd275000000;
  localparam logic [HZ_W-1:0]  CORE_HZ_RST = 30'd550000000;
  localparam logic [UPT_W-1:0] US_TICK_RST = 20'd1000;

  typedef struct packed {
    logic [COUNT_W-1:0] fine_count;
    logic [COUNT_W-1:0] tick_count;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic              coarse_only;
  } out_item_t;

endpackage

// File: sv/cft_div_cell.sv
// One restoring-division cell: takes one dividend bit, emits one quotient bit.
// Depends on nothing; chained by cft_div_chain.
module cft_div_cell #(
  parameter int NUM_W  = 52,
  parameter int DEN_W  = 30,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [NUM_W-1:0]  in_quo,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_num,
  output logic [NUM_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [DEN_W-1:0]  out_den,
  output logic [SIDE_W-1:0] out_side
);

  logic              valid_r;
  logic [NUM_W-1:0]  num_r, quo_r;
  logic [DEN_W-1:0]  rem_r, den_r;
  logic [SIDE_W-1:0] side_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              take;
  logic [DEN_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {in_rem, in_num[NUM_W-1]};
    diff    = trial - {1'b0, in_den};
    take    = (trial >= {1'b0, in_den});
    // when no subtract happens trial < den, so it fits the remainder width
    rem_nxt = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= in_num << 1;
      quo_r  <= {in_quo[NUM_W-2:0], take};
      rem_r  <= rem_nxt;
      den_r  <= in_den;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_num   = num_r;
  assign out_quo   = quo_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_side  = side_r;

endmodule

// File: sv/cft_div_chain.sv
// Row of NUM_W division cells, one quotient bit per cell, one item per cycle while en is high.
// Depends on cft_div_cell.
module cft_div_chain #(
  parameter int NUM_W  = 52,
  parameter int DEN_W  = 30,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  logic              v   [NUM_W+1];
  logic [NUM_W-1:0]  num [NUM_W+1];
  logic [NUM_W-1:0]  quo [NUM_W+1];
  logic [DEN_W-1:0]  rem [NUM_W+1];
  logic [DEN_W-1:0]  den [NUM_W+1];
  logic [SIDE_W-1:0] side[NUM_W+1];

  assign v[0]    = in_valid;
  assign num[0]  = in_num;
  assign quo[0]  = '0;
  assign rem[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    cft_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v[i]),
      .in_num   (num[i]),
      .in_quo   (quo[i]),
      .in_rem   (rem[i]),
      .in_den   (den[i]),
      .in_side  (side[i]),
      .out_valid(v[i+1]),
      .out_num  (num[i+1]),
      .out_quo  (quo[i+1]),
      .out_rem  (rem[i+1]),
      .out_den  (den[i+1]),
      .out_side (side[i+1])
    );
  end

  assign out_valid = v[NUM_W];
  assign out_quo   = quo[NUM_W];
  assign out_rem   = rem[NUM_W];
  assign out_side  = side[NUM_W];

endmodule

// File: sv/coarse_fine_microsecond_timestamp.sv
// Coarse/fine microsecond timestamp merge, top level.
// Depends on cft_pkg and cft_div_chain.
//
// Usage:
//   in_valid/in_stall carry {fine_count, tick_count}; out_valid/out_stall carry
//   {time_us, coarse_only}, one result per input transaction, in order.
//   cfg_valid/cfg_ready writes register cfg_index (0 bus Hz, 1 core Hz,
//   2 multiplier select, 3 us per tick, 4 fine enable); cfg_ready is always
//   high. Write registers only while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled.
// Pipeline: one product stage, a FINE_COUNTER_BITS+20 cell divider row by the
//   timer clock (fine time and wrap period), one align stage, a 53 cell
//   remainder row by the period, and the output register.
// Stall: when out_stall holds a valid result, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped.
// Reset: synchronous rst_n empties the pipeline and loads the default clocks
//   (275 MHz bus, 550 MHz core, x2), 1000 us per tick and fine counting on.
module coarse_fine_microsecond_timestamp #(
  parameter int FINE_COUNTER_BITS = cft_pkg::FINE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cft_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cft_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cft_pkg::HZ_W-1:0]            cfg_data
);
  import cft_pkg::*;

  localparam int PROD_W = FINE_COUNTER_BITS + UPT_W;
  localparam logic [PROD_W-1:0] PERIOD_NUM = PROD_W'(US_PER_SEC) << FINE_COUNTER_BITS;
  localparam int SIDE2_W = TIME_W + PROD_W + 2;

  // configuration
  logic [HZ_W-1:0]  bus_hz_r, core_hz_r;
  logic             mul_sel_r, fine_en_r;
  logic [UPT_W-1:0] us_tick_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_hz_r  <= BUS_HZ_RST;
      core_hz_r <= CORE_HZ_RST;
      mul_sel_r <= 1'b0;
      us_tick_r <= US_TICK_RST;
      fine_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUS_HZ:  bus_hz_r  <= cfg_data;
        CFG_CORE_HZ: core_hz_r <= cfg_data;
        CFG_MUL_SEL: mul_sel_r <= cfg_data[0];
        CFG_US_TICK: us_tick_r <= cfg_data[UPT_W-1:0];
        CFG_FINE_EN: fine_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // timer clock: product never exceeds 32 bits, result never exceeds core Hz
  logic [HZ_W+1:0] scaled;
  logic [HZ_W-1:0] hz;

  always_comb begin
    scaled = {2'b00, bus_hz_r} << (mul_sel_r ? 2 : 1);
    if (bus_hz_r == core_hz_r) begin
      hz = core_hz_r;
    end else if (scaled > {2'b00, core_hz_r}) begin
      hz = core_hz_r;
    end else begin
      hz = scaled[HZ_W-1:0];
    end
  end

  logic en;
  logic out_valid_r;
  out_item_t out_item_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage 0: products
  logic                 s0_valid_r;
  logic [PROD_W-1:0]    s0_fine_prod_r;
  logic [TICK_US_W-1:0] s0_tick_us_r;
  logic [HZ_W-1:0]      s0_hz_r;
  logic                 s0_coarse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_fine_prod_r <= PROD_W'(in_data.fine_count[FINE_COUNTER_BITS-1:0]) *
                        PROD_W'(US_PER_SEC);
      s0_tick_us_r   <= TICK_US_W'(in_data.tick_count) * TICK_US_W'(us_tick_r);
      s0_hz_r        <= hz;
      s0_coarse_r    <= !fine_en_r || (hz == '0);
    end
  end

  // divider rows by the timer clock
  logic                 fd_valid, pd_valid;
  logic [PROD_W-1:0]    fine_us, period;
  logic [HZ_W-1:0]      fd_rem, pd_rem;
  logic                 fd_coarse;
  logic [TICK_US_W-1:0] pd_tick_us;

  cft_div_chain #(.NUM_W(PROD_W), .DEN_W(HZ_W), .SIDE_W(1)) u_fine_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s0_valid_r),
    .in_num   (s0_fine_prod_r),
    .in_den   (s0_hz_r),
    .in_side  (s0_coarse_r),
    .out_valid(fd_valid),
    .out_quo  (fine_us),
    .out_rem  (fd_rem),
    .out_side (fd_coarse)
  );

  cft_div_chain #(.NUM_W(PROD_W), .DEN_W(HZ_W), .SIDE_W(TICK_US_W)) u_period_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s0_valid_r),
    .in_num   (PERIOD_NUM),
    .in_den   (s0_hz_r),
    .in_side  (s0_tick_us_r),
    .out_valid(pd_valid),
    .out_quo  (period),
    .out_rem  (pd_rem),
    .out_side (pd_tick_us)
  );

  // stage B: align to the nearest wrap
  logic              b_valid_r;
  logic [TIME_W-1:0] b_sum_r, b_x_r;
  logic [PROD_W-1:0] b_fine_us_r, b_period_r;
  logic              b_ge_r, b_coarse_r;
  logic [TIME_W-1:0] sum_nxt;
  logic              ge_nxt;

  always_comb begin
    sum_nxt = fd_coarse ? TIME_W'(pd_tick_us)
                        : TIME_W'(pd_tick_us) + TIME_W'(period >> 1);
    ge_nxt  = (sum_nxt >= TIME_W'(fine_us));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= fd_valid && pd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sum_r     <= sum_nxt;
      b_x_r       <= ge_nxt ? sum_nxt - TIME_W'(fine_us) : '0;
      b_fine_us_r <= fine_us;
      b_period_r  <= period;
      b_ge_r      <= ge_nxt;
      b_coarse_r  <= fd_coarse;
    end
  end

  // remainder row by the wrap period
  logic               c_valid;
  logic [TIME_W-1:0]  c_quo;
  logic [PROD_W-1:0]  c_rem;
  logic [SIDE2_W-1:0] c_side;
  logic [TIME_W-1:0]  c_sum;
  logic [PROD_W-1:0]  c_fine_us;
  logic               c_ge, c_coarse;

  cft_div_chain #(.NUM_W(TIME_W), .DEN_W(PROD_W), .SIDE_W(SIDE2_W)) u_wrap_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (b_valid_r),
    .in_num   (b_x_r),
    .in_den   (b_period_r),
    .in_side  ({b_sum_r, b_fine_us_r, b_ge_r, b_coarse_r}),
    .out_valid(c_valid),
    .out_quo  (c_quo),
    .out_rem  (c_rem),
    .out_side (c_side)
  );

  assign {c_sum, c_fine_us, c_ge, c_coarse} = c_side;

  // result = wraps*period + fine_us = sum - remainder, or sum if coarse; below 2^53
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r.coarse_only <= c_coarse;
      if (c_coarse) begin
        out_item_r.time_us <= c_sum;
      end else if (c_ge) begin
        out_item_r.time_us <= c_sum - TIME_W'(c_rem);
      end else begin
        out_item_r.time_us <= TIME_W'(c_fine_us);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef ASSERT_OFF
  a_rows_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    fd_valid == pd_valid)
    else $error("divider rows out of step");

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !b_coarse_r |-> b_period_r != '0)
    else $error("zero wrap period on fine path");

  a_rem_fits: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid && !c_coarse && c_ge |-> TIME_W'(c_rem) <= c_sum)
    else $error("wrap remainder exceeds aligned sum");

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid && !c_coarse && !c_ge |-> c_quo == '0)
    else $error("nonzero wraps below first wrap");
`endif

endmodule
